// ===== hdl/urrf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urrf_pkg
// Shared types and constants of the UART receive ring FIFO: ring geometry,
// interrupt id codes, line status masks and the control/status structs.
// ----------------------------------------------------------------------------
package urrf_pkg;

  // Ring geometry
  localparam int unsigned DEPTH = 64;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Stream widths
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 4;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned OUT_CNT_W  = 7;
  localparam int unsigned ERR_W      = 9;

  // Item kind
  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Interrupt ids
  localparam logic [2:0] ID_DATA    = 3'd2;
  localparam logic [2:0] ID_LINE    = 3'd3;
  localparam logic [2:0] ID_TIMEOUT = 3'd6;

  // Line status: overrun, parity, framing, break, fifo error
  localparam logic [7:0] ERR_BITS   = 8'h9E;
  localparam int unsigned READY_BIT = 0;
  localparam int unsigned TMO_BIT   = 8;

  // Controller to datapath
  typedef struct packed {
    logic latch;  // capture the accepted item
    logic exec;   // apply the item to the ring and flags
    logic load;   // move the result into the output register
  } urrf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;  // output register holds an untaken result
  } urrf_sts_t;

endpackage

// ===== hdl/uart_rx_ring_fifo_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rx_ring_fifo_top
// UART receive ring FIFO: interrupt events push bytes or record line status,
// read items pop the oldest byte; every item returns one status result.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): tuser = {int_id, op}, tdata = {rx_byte, line_status}.
//   op = 0 is a receive interrupt event, op = 1 pops one byte.
//   Output stream (m_axis): one item per input item carrying the popped byte
//   (zero on events and empty reads), the fill count, the overflow, full and
//   not-empty flags, and the last error status with the timeout mark in bit 8.
//   Each item passes through capture, update and result load in turn before its
//   result is valid, and no new item is taken until the one in hand is loaded;
//   the ring memory gives one access per item.
//   Reset clears pointers, count, flags and error status; the byte ring is not
//   cleared, since only written entries are ever read.
//   When the receiver stalls, the result holds on m_axis; the block can take and update one
//   more item but loads its result and takes no further one until the held result is taken.
// ----------------------------------------------------------------------------
module uart_rx_ring_fifo_top
  import urrf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // [7:0] line_status, [15:8] rx_byte
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,   // [0] op, [3:1] int_id
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o    // [7:0] read_data, [14:8] fifo_count,
                                                  // [15] overflow_seen, [16] full_seen,
                                                  // [17] has_data,
                                                  // [26:18] rx_error_status
);

  urrf_cmd_t cmd;
  urrf_sts_t sts;

  // Sequencer
  urrf_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  // Ring and flags
  urrf_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

// ===== hdl/urrf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urrf_ctrl
// Sequencer: takes one item, runs its update step, then hands the result to
// the output register once that register is free.
// ----------------------------------------------------------------------------
module urrf_ctrl
  import urrf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_axis_tvalid_i,
  output logic      s_axis_tready_o,
  input  urrf_sts_t sts_i,
  output urrf_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_e;

  state_e state_q;
  logic   ready_q;
  logic   exec_q;

  // Sequence one item at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
      exec_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            state_q <= S_EXEC;
            ready_q <= 1'b0;
            exec_q  <= 1'b1;
          end
        end
        S_EXEC: begin
          exec_q  <= 1'b0;
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          if (!sts_i.out_busy) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b1;
          exec_q  <= 1'b0;
        end
      endcase
    end
  end

  // Drive commands
  assign s_axis_tready_o = ready_q;
  assign cmd_o.latch     = s_axis_tvalid_i && ready_q;
  assign cmd_o.exec      = exec_q;
  assign cmd_o.load      = (state_q == S_LOAD) && !sts_i.out_busy;

endmodule

// ===== hdl/urrf_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urrf_datapath
// Byte ring with pointers, fill count, status flags and the output register.
// ----------------------------------------------------------------------------
module urrf_datapath
  import urrf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  urrf_cmd_t             cmd_i,
  output urrf_sts_t             sts_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // line_status, rx_byte
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,   // op, int_id
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o    // read_data, fifo_count,
                                                  // overflow_seen, full_seen,
                                                  // has_data, rx_error_status
);

  localparam int unsigned CNT_X = CNT_W + OUT_CNT_W;

  // Captured item
  logic       op_q;
  logic [2:0] id_q;
  logic [7:0] ls_q;
  logic [7:0] rb_q;

  // Ring state
  logic [7:0]       mem [DEPTH];
  logic [PTR_W-1:0] wpos_q, rpos_q;
  logic [CNT_W-1:0] cnt_q;
  logic             ovf_q, full_q, nempty_q;
  logic [ERR_W-1:0] err_q;
  logic [7:0]       rd_q;
  logic             pop_hit_q;

  // Output register
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  // Decode
  logic             is_line, has_err, push_req, pop_req, at_full, is_empty;
  logic [CNT_X-1:0] cnt_ext;

  assign is_line  = (op_q == OP_EVENT) && (id_q == ID_LINE);
  assign has_err  = (ls_q & ERR_BITS) != 8'd0;
  assign push_req = (op_q == OP_EVENT) && (rb_q != 8'd0) &&
                    ((is_line && !has_err && ls_q[READY_BIT]) || (id_q == ID_DATA));
  assign pop_req  = (op_q == OP_READ);
  assign at_full  = (cnt_q == CNT_W'(DEPTH));
  assign is_empty = (cnt_q == '0);
  assign cnt_ext  = CNT_X'(cnt_q);

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q <= s_axis_tuser_i[0];
      id_q <= s_axis_tuser_i[3:1];
      ls_q <= s_axis_tdata_i[7:0];
      rb_q <= s_axis_tdata_i[15:8];
    end
  end

  // Ring storage: write on push, registered read on pop
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && push_req && !at_full) begin
      mem[wpos_q] <= rb_q;
    end
    if (cmd_i.exec && pop_req && !is_empty) begin
      rd_q <= mem[rpos_q];
    end
  end

  // Update pointers, count and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q    <= '0;
      rpos_q    <= '0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      full_q    <= 1'b0;
      nempty_q  <= 1'b0;
      err_q     <= '0;
      pop_hit_q <= 1'b0;
    end else if (cmd_i.exec) begin
      pop_hit_q <= pop_req && !is_empty;
      if (pop_req) begin
        if (at_full) begin
          full_q <= 1'b0;
        end
        if (!is_empty) begin
          rpos_q <= (rpos_q == PTR_W'(DEPTH - 1)) ? '0 : rpos_q + 1'b1;
          cnt_q  <= cnt_q - 1'b1;
        end else begin
          nempty_q <= 1'b0;
        end
      end else if (push_req) begin
        if (at_full) begin
          ovf_q  <= 1'b1;
          full_q <= 1'b1;
        end else begin
          wpos_q <= (wpos_q == PTR_W'(DEPTH - 1)) ? '0 : wpos_q + 1'b1;
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(DEPTH - 1)) begin
            full_q <= 1'b1;
          end
        end
        nempty_q <= 1'b1;
      end else if (is_line && has_err) begin
        err_q <= {1'b0, ls_q};
      end else if ((op_q == OP_EVENT) && (id_q == ID_TIMEOUT)) begin
        err_q[TMO_BIT] <= 1'b1;
      end
    end
  end

  // Output register: load a result, drop it when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_q <= {5'd0, err_q, nempty_q, full_q, ovf_q, cnt_ext[OUT_CNT_W-1:0],
                     pop_hit_q ? rd_q : 8'd0};
    end
  end

  assign sts_o.out_busy  = out_valid_q && !m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== hdl/urrf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urrf_checker
// Port-level checks of the UART receive ring FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module urrf_checker
  import urrf_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o    // read_data, fifo_count, flags, status
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // One item in flight: no new item during its update and load steps
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o ##1 !s_axis_tready_o)
    else $error("item taken while another is in flight");

  // Empty flag clear means an empty ring
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[17] |-> m_axis_tdata_o[14:8] == 7'd0)
    else $error("count nonzero with not-empty flag clear");

  // Full flag only with the ring at depth
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[16] |->
      m_axis_tdata_o[14:8] == OUT_CNT_W'(DEPTH))
    else $error("full flag with ring below depth");

endmodule

bind uart_rx_ring_fifo_top urrf_checker u_urrf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ===== tb/sv/uart_rx_ring_fifo_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rx_ring_fifo_top_test
// Self-checking bench for the UART receive ring FIFO. Interrupt events and
// read items go in on the input stream. A scoreboard keeps its own ring,
// flags and error status, works out the status item that each accepted input
// item must produce, and compares it field by field with the output stream.
// Directed corner cases come first. Bursts of pushes and reads with random
// content follow, which drive the ring through full, overflow and empty
// reads, under three different backpressure settings.
// ----------------------------------------------------------------------------
module uart_rx_ring_fifo_top_test;
  import urrf_pkg::*;

  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 300;
  localparam int unsigned MAX_REPORTS = 10;

  // Output item, lowest field last
  typedef struct packed {
    logic [4:0]           pad;
    logic [ERR_W-1:0]     err_status;
    logic                 has_data;
    logic                 full_seen;
    logic                 overflow_seen;
    logic [OUT_CNT_W-1:0] fifo_count;
    logic [7:0]           read_data;
  } rx_status_t;

  // --------------------------------------------------------------------------
  // Scoreboard: ring model plus the queue of status items still to arrive
  // --------------------------------------------------------------------------
  class rx_fifo_scoreboard;
    logic [7:0]       ring [DEPTH];
    int unsigned      wr_idx;
    int unsigned      rd_idx;
    int unsigned      held;
    bit               ovf_flag;
    bit               full_flag;
    bit               nonempty_flag;
    logic [ERR_W-1:0] err_status;
    rx_status_t       status_due [$];
    int unsigned      mismatches;

    function new();
      wr_idx        = 0;
      rd_idx        = 0;
      held          = 0;
      ovf_flag      = 1'b0;
      full_flag     = 1'b0;
      nonempty_flag = 1'b0;
      err_status    = '0;
      mismatches    = 0;
    endfunction

    // Store a received byte; zero bytes leave everything untouched
    function void push_byte(logic [7:0] b);
      if (b == 8'h00) return;
      if (held >= DEPTH) begin
        ovf_flag = 1'b1;
      end else begin
        ring[wr_idx] = b;
        wr_idx = (wr_idx + 1) % DEPTH;
        held++;
      end
      if (held == DEPTH) full_flag = 1'b1;
      nonempty_flag = 1'b1;
    endfunction

    // Apply one accepted input item and queue the status it must produce
    function void note_item(logic op, logic [2:0] id, logic [7:0] ls, logic [7:0] rb);
      rx_status_t s;
      s = '0;
      if (op == OP_READ) begin
        if (held == DEPTH) full_flag = 1'b0;
        if (held > 0) begin
          s.read_data = ring[rd_idx];
          rd_idx = (rd_idx + 1) % DEPTH;
          held--;
        end else begin
          nonempty_flag = 1'b0;
        end
      end else begin
        case (id)
          ID_LINE: begin
            if ((ls & ERR_BITS) != 0) err_status = {1'b0, ls};
            else if (ls[READY_BIT]) push_byte(rb);
          end
          ID_DATA:    push_byte(rb);
          ID_TIMEOUT: err_status[TMO_BIT] = 1'b1;
          default: ;
        endcase
      end
      s.fifo_count    = OUT_CNT_W'(held);
      s.overflow_seen = ovf_flag;
      s.full_seen     = full_flag;
      s.has_data      = nonempty_flag;
      s.err_status    = err_status;
      status_due.push_back(s);
    endfunction

    // Compare one output item with the oldest expected status
    function void check_item(logic [OUT_DATA_W-1:0] word);
      rx_status_t got;
      rx_status_t want;
      got = word;
      if (status_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected output item %h", word);
        return;
      end
      want = status_due.pop_front();
      if (got.read_data !== want.read_data || got.fifo_count !== want.fifo_count ||
          got.overflow_seen !== want.overflow_seen || got.full_seen !== want.full_seen ||
          got.has_data !== want.has_data || got.err_status !== want.err_status ||
          got.pad !== want.pad) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"mismatch (exp/act): data %h/%h count %0d/%0d ovf %b/%b full %b/%b ",
                    "nonempty %b/%b err %h/%h pad %h/%h"},
                   want.read_data, got.read_data, want.fifo_count, got.fifo_count,
                   want.overflow_seen, got.overflow_seen, want.full_seen, got.full_seen,
                   want.has_data, got.has_data, want.err_status, got.err_status,
                   want.pad, got.pad);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_tvalid;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [IN_USER_W-1:0]  s_tuser;
  logic                  m_tready;
  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  rx_fifo_scoreboard sb;
  int unsigned       snd_idle_pct;
  int unsigned       rcv_idle_pct;
  int unsigned       counted;
  int unsigned       quiet_cycles;

  uart_rx_ring_fifo_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offer one item after optional idle cycles and hold it until accepted
  task automatic send_item(logic op, logic [2:0] id, logic [7:0] ls, logic [7:0] rb);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tdata  = {rb, ls};
    s_tuser  = {id, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_item(op, id, ls, rb);
    // Every accepted item advances the stimulus budget
    counted++;
  endtask

  // Well-formed push: data event or clean line status with ready set
  task automatic send_push();
    if ($urandom_range(1)) send_item(OP_EVENT, ID_DATA, 8'($urandom), 8'($urandom_range(1, 255)));
    else send_item(OP_EVENT, ID_LINE, (8'($urandom) & 8'h61) | 8'h01, 8'($urandom_range(1, 255)));
  endtask

  // One burst: fill, drain or fully random, with some noise mixed in
  task automatic send_segment();
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(9);
    len  = (kind >= 7) ? 20 : $urandom_range(10, 75);
    for (int unsigned i = 0; i < len; i++) begin
      if (kind >= 7 || $urandom_range(9) == 0)
        send_item(1'($urandom_range(1)), 3'($urandom_range(7)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
      else if (kind < 4)
        send_push();
      else
        send_item(OP_READ, 3'($urandom_range(7)), 8'($urandom), 8'($urandom));
    end
  endtask

  // Corner cases: every interrupt id, every error bit, zero bytes, empty reads
  task automatic send_directed();
    send_item(OP_READ,  ID_DATA,    8'h00, 8'h00);   // read of an empty ring
    send_item(OP_EVENT, ID_TIMEOUT, 8'hFF, 8'hFF);   // timeout mark
    send_item(OP_EVENT, ID_LINE,    8'h02, 8'h55);   // overrun, clears timeout mark
    send_item(OP_EVENT, ID_LINE,    8'h05, 8'h56);   // parity with ready: still dropped
    send_item(OP_EVENT, ID_LINE,    8'h08, 8'h57);
    send_item(OP_EVENT, ID_LINE,    8'h10, 8'h58);
    send_item(OP_EVENT, ID_LINE,    8'h80, 8'h59);
    send_item(OP_EVENT, ID_LINE,    8'hFF, 8'hFF);
    send_item(OP_EVENT, ID_LINE,    8'h01, 8'hA5);   // clean and ready: push
    send_item(OP_EVENT, ID_LINE,    8'h61, 8'hFF);   // bits 5 and 6 are no errors
    send_item(OP_EVENT, ID_LINE,    8'h00, 8'h33);   // not ready: no change
    send_item(OP_EVENT, ID_LINE,    8'h60, 8'h34);
    send_item(OP_EVENT, ID_LINE,    8'h01, 8'h00);   // zero byte ignored
    send_item(OP_EVENT, ID_DATA,    8'hFF, 8'h01);   // line status ignored
    send_item(OP_EVENT, ID_DATA,    8'h00, 8'h00);   // zero byte ignored
    for (int unsigned id = 0; id < 8; id++)
      if (id != ID_DATA && id != ID_LINE && id != ID_TIMEOUT)
        send_item(OP_EVENT, 3'(id), 8'hFF, 8'hC3);   // unused ids
    for (int unsigned i = 0; i < 4; i++)
      send_item(OP_READ, 3'h7, 8'hFF, 8'hFF);        // pop three, then empty read
    send_item(OP_EVENT, ID_TIMEOUT, 8'h00, 8'h00);
  endtask

  // Stimulus sequence
  initial begin
    sb           = new();
    snd_idle_pct = 7;
    rcv_idle_pct = 73;
    counted      = 0;
    rst_ni       = 1'b0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    m_tready     = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_directed();
    counted = 0;
    for (int unsigned ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 73 : 0;
      rcv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 7 : 0;
      while (counted < (ph + 1) * PHASE_ITEMS) send_segment();
      // Hold off the sender until the output side has caught up
      if (ph == 0) begin
        @(negedge clk_i);
        s_tvalid = 1'b0;
        while (sb.status_due.size() != 0) @(posedge clk_i);
      end
    end

    // Drain and let the block settle
    @(negedge clk_i);
    s_tvalid = 1'b0;
    while (sb.status_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.status_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------
  // Randomize backpressure at the falling edge
  initial begin
    forever begin
      @(negedge clk_i);
      if (rst_ni) m_tready = ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Check every accepted output item
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_tready) sb.check_item(m_axis_tdata_o);
    end
  end

  // Watchdog: end the run when no item moves on either side for too long
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
hdl/urrf_pkg.sv
hdl/urrf_ctrl.sv
hdl/urrf_datapath.sv
hdl/uart_rx_ring_fifo_top.sv
hdl/urrf_checker.sv
tb/sv/uart_rx_ring_fifo_top_test.sv
